### rtl/core/gs1d_pkg.sv
// Shared types, constants and helpers for the 1D Gauss-Seidel Laplace solver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gs1d_pkg;

  // Number of cells in the field.
  localparam int CELLS = 16;
  localparam int IDX_W = $clog2(CELLS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WALL_TEMPERATURE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_FLUX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT      = 3'd4;

  typedef struct packed {
    logic signed [31:0] wall_temperature;
    logic signed [31:0] wall_flux;
    logic [30:0]        cell_width;
    logic [30:0]        tolerance;
    logic [15:0]        sweep_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ZERO,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RD_LAST,
    ST_RD_FIRST,
    ST_RD_SECOND,
    ST_CELL,
    ST_FLUSH,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef enum logic [1:0] {
    WR_ITEM,
    WR_ZERO,
    WR_CELL
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             solve_start;
    logic             mul_lo;
    logic             mul_hi;
    logic             sweep_start;
    logic             ghost_right;
    logic             ghost_left;
    logic             relax;
    logic             first;
    logic             lastc;
    logic             finish;
    logic             emit;
    logic             mem_we;
    wr_sel_t          wr_sel;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic converged;
    logic limit_hit;
    logic out_free;
  } status_t;

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/gs1d_cfg.sv
// Configuration register file of the solver.
// Depends on gs1d_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module gs1d_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [gs1d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gs1d_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gs1d_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_temperature <= 32'sd6553600;
      cfg.wall_flux        <= 32'sd6553600;
      cfg.cell_width       <= 31'd6554;
      cfg.tolerance        <= 31'd0;
      cfg.sweep_limit      <= 16'd65535;
    end else if (cfg_write) begin
      case (cfg_index)
        gs1d_pkg::REG_WALL_TEMPERATURE: cfg.wall_temperature <= cfg_data;
        gs1d_pkg::REG_WALL_FLUX:        cfg.wall_flux        <= cfg_data;
        gs1d_pkg::REG_CELL_WIDTH:       cfg.cell_width       <= cfg_data[30:0];
        gs1d_pkg::REG_TOLERANCE:        cfg.tolerance        <= cfg_data[30:0];
        gs1d_pkg::REG_SWEEP_LIMIT:      cfg.sweep_limit      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/gs1d_ctrl.sv
// Sequencer of the solver: loading, zero fill, sweeps, convergence test, emission.
// Depends on gs1d_pkg; drives gs1d_dp through cmd_t and reads status_t.
`default_nettype none

module gs1d_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire logic            last,
  input  gs1d_pkg::status_t    status,
  output gs1d_pkg::cmd_t       cmd
);

  gs1d_pkg::state_t state, state_next;
  logic [gs1d_pkg::IDX_W-1:0] count, count_next;
  logic [gs1d_pkg::IDX_W-1:0] idx, idx_next;
  logic [gs1d_pkg::IDX_W:0]   ahead;
  logic                       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gs1d_pkg::ST_LOAD;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // Read address two cells ahead of the one being relaxed; past the end it is unused.
  assign ahead = {1'b0, idx} + (gs1d_pkg::IDX_W + 1)'(2);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    item_stall = (state != gs1d_pkg::ST_LOAD);
    accept     = item_valid && !item_stall;

    case (state)
      gs1d_pkg::ST_LOAD: begin
        if (accept) begin
          cmd.mem_we = 1'b1;
          cmd.wr_sel = gs1d_pkg::WR_ITEM;
          cmd.waddr  = count;
          if (last || count == gs1d_pkg::LAST_IDX) begin
            cmd.solve_start = 1'b1;
            count_next      = '0;
            if (count == gs1d_pkg::LAST_IDX) begin
              state_next = gs1d_pkg::ST_MUL_LO;
            end else begin
              idx_next   = count + 1'b1;
              state_next = gs1d_pkg::ST_ZERO;
            end
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      gs1d_pkg::ST_ZERO: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = gs1d_pkg::WR_ZERO;
        cmd.waddr  = idx;
        if (idx == gs1d_pkg::LAST_IDX) begin
          state_next = gs1d_pkg::ST_MUL_LO;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      gs1d_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = gs1d_pkg::ST_MUL_HI;
      end
      gs1d_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = gs1d_pkg::ST_RD_LAST;
      end
      gs1d_pkg::ST_RD_LAST: begin
        cmd.sweep_start = 1'b1;
        cmd.raddr       = gs1d_pkg::LAST_IDX;
        state_next      = gs1d_pkg::ST_RD_FIRST;
      end
      gs1d_pkg::ST_RD_FIRST: begin
        cmd.ghost_right = 1'b1;
        cmd.raddr       = '0;
        state_next      = gs1d_pkg::ST_RD_SECOND;
      end
      gs1d_pkg::ST_RD_SECOND: begin
        cmd.ghost_left = 1'b1;
        cmd.raddr      = gs1d_pkg::IDX_W'(1);
        idx_next       = '0;
        state_next     = gs1d_pkg::ST_CELL;
      end
      gs1d_pkg::ST_CELL: begin
        cmd.relax  = 1'b1;
        cmd.first  = (idx == '0);
        cmd.lastc  = (idx == gs1d_pkg::LAST_IDX);
        cmd.mem_we = 1'b1;
        cmd.wr_sel = gs1d_pkg::WR_CELL;
        cmd.waddr  = idx;
        cmd.raddr  = (ahead >= (gs1d_pkg::IDX_W + 1)'(gs1d_pkg::CELLS)) ?
                     '0 : ahead[gs1d_pkg::IDX_W-1:0];
        if (idx == gs1d_pkg::LAST_IDX) begin
          state_next = gs1d_pkg::ST_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      gs1d_pkg::ST_FLUSH: begin
        state_next = gs1d_pkg::ST_CHECK;
      end
      gs1d_pkg::ST_CHECK: begin
        if (status.converged || status.limit_hit) begin
          cmd.finish = 1'b1;
          idx_next   = '0;
          state_next = gs1d_pkg::ST_EMIT_RD;
        end else begin
          state_next = gs1d_pkg::ST_RD_LAST;
        end
      end
      gs1d_pkg::ST_EMIT_RD: begin
        cmd.raddr  = idx;
        state_next = gs1d_pkg::ST_EMIT_LD;
      end
      gs1d_pkg::ST_EMIT_LD: begin
        cmd.raddr = idx;
        cmd.lastc = (idx == gs1d_pkg::LAST_IDX);
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (idx == gs1d_pkg::LAST_IDX) begin
            state_next = gs1d_pkg::ST_LOAD;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = gs1d_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = gs1d_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/gs1d_dp.sv
// Datapath of the solver: field memory, boundary product, ghosts, relaxation,
// change tracking and the output register. Depends on gs1d_pkg.
`default_nettype none

module gs1d_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  gs1d_pkg::cfg_t            cfg,
  input  gs1d_pkg::cmd_t            cmd,
  output gs1d_pkg::status_t         status,
  input  wire logic signed [31:0]   initial_value,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic signed [31:0]        cell_value,
  output logic [5:0]                cell_index,
  output logic [15:0]               sweeps_done,
  output logic                      not_converged,
  output logic                      final_cell
);

  logic signed [31:0] cells_mem [gs1d_pkg::CELLS];
  logic signed [31:0] rdata;
  logic signed [31:0] wdata;

  logic signed [16:0] w_lo;
  logic signed [15:0] w_hi;
  logic signed [48:0] prod_lo;
  logic signed [48:0] round_lo;
  logic signed [48:0] prod_hi;
  logic signed [32:0] t_lo;
  logic signed [31:0] flux_width;

  logic signed [31:0] left_ghost;
  logic signed [31:0] right_ghost;
  logic signed [31:0] cur;
  logic signed [31:0] prev;
  logic signed [32:0] nsum;
  logic signed [31:0] nv;
  logic signed [32:0] diff;
  logic               diff_valid;
  logic [32:0]        abs_diff;
  logic [31:0]        largest_change;
  logic [15:0]        sweeps;
  logic [15:0]        limit_eff;
  logic               nc;

  // Field memory: one write and one registered read per cycle.
  always_comb begin
    case (cmd.wr_sel)
      gs1d_pkg::WR_ITEM: wdata = initial_value;
      gs1d_pkg::WR_ZERO: wdata = '0;
      gs1d_pkg::WR_CELL: wdata = nv;
      default:           wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      cells_mem[cmd.waddr] <= wdata;
    end
    rdata <= cells_mem[cmd.raddr];
  end

  // flux*width rounded to nearest, split over two 32x16 products.
  // The high part is a multiple of 2^16, so the rounding lives in the low part alone.
  assign w_lo     = $signed({1'b0, cfg.cell_width[15:0]});
  assign w_hi     = $signed({1'b0, cfg.cell_width[30:16]});
  assign prod_lo  = 49'(cfg.wall_flux) * 49'(w_lo);
  assign round_lo = prod_lo + 49'sd32768;
  assign prod_hi  = 49'(cfg.wall_flux) * 49'(w_hi);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      t_lo <= round_lo[48:16];
    end
    if (cmd.mul_hi) begin
      flux_width <= gs1d_pkg::sat32(prod_hi + 49'(t_lo));
    end
  end

  // Relaxation of one cell: floor of the halved neighbour sum.
  assign nsum = 33'(cmd.first ? left_ghost : prev) + 33'(cmd.lastc ? right_ghost : rdata);
  assign nv   = nsum[32:1];

  always_ff @(posedge clk) begin
    if (cmd.ghost_right) begin
      right_ghost <= gs1d_pkg::sat32(49'(flux_width) + 49'(rdata));
    end
    if (cmd.ghost_left) begin
      left_ghost <= gs1d_pkg::sat32(49'(cfg.wall_temperature) + 49'(cfg.wall_temperature)
                                    - 49'(rdata));
      cur        <= rdata;
    end
    if (cmd.relax) begin
      diff <= 33'(nv) - 33'(cur);
      cur  <= rdata;
      prev <= nv;
    end
  end

  // The difference of two 32-bit values never exceeds 2^32-1 in magnitude.
  assign abs_diff = diff[32] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid     <= 1'b0;
      largest_change <= '0;
      sweeps         <= '0;
      nc             <= 1'b0;
    end else begin
      diff_valid <= cmd.relax;
      if (cmd.sweep_start) begin
        largest_change <= '0;
      end else if (diff_valid && (abs_diff[31:0] > largest_change)) begin
        largest_change <= abs_diff[31:0];
      end
      if (cmd.solve_start) begin
        sweeps <= '0;
      end else if (cmd.sweep_start) begin
        sweeps <= sweeps + 1'b1;
      end
      if (cmd.finish) begin
        nc <= !status.converged;
      end
    end
  end

  assign limit_eff        = (cfg.sweep_limit == '0) ? 16'd1 : cfg.sweep_limit;
  assign status.converged = ({1'b0, cfg.tolerance} >= largest_change);
  assign status.limit_hit = (sweeps >= limit_eff);
  assign status.out_free  = !result_valid || !result_stall;

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_value    <= rdata;
      cell_index    <= 6'(cmd.idx);
      sweeps_done   <= sweeps;
      not_converged <= nc;
      final_cell    <= cmd.lastc;
    end
  end

endmodule

`default_nettype wire

### rtl/core/gauss_seidel_1d_laplace_solver.sv
// Top level of the 1D Gauss-Seidel Laplace solver.
// Depends on gs1d_pkg, gs1d_cfg, gs1d_ctrl and gs1d_dp.
//
// Usage:
//   Input channel (item_valid/item_stall) loads one cell per transfer, in Q16.16.
//   A transfer with last set, or the one that fills the final cell, starts the
//   solve; cells not loaded in that run start at zero. One transfer per cycle
//   is taken while loading; item_stall stays high for the whole solve.
//   Output channel (result_valid/result_stall) gives one transfer per cell, in
//   order, with the sweep count and the non-convergence flag; final_cell marks
//   the last. A stall holds the output register and pauses the emission.
//   A solve zero-fills the cells left unloaded, forms the boundary product in a low
//   and a high step, then runs sweeps whose reads share the single read port of
//   the field memory, then reads each cell out to the output register in turn.
//   Loading of the next run starts as soon as the last result sits in the
//   output register.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle.
//   Reset is synchronous: it restores the register defaults, returns to loading
//   with an empty load count and drops result_valid.
`default_nettype none

module gauss_seidel_1d_laplace_solver (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic signed [31:0]               initial_value,
  input  wire logic                             last,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic signed [31:0]                    cell_value,
  output logic [5:0]                            cell_index,
  output logic [15:0]                           sweeps_done,
  output logic                                  not_converged,
  output logic                                  final_cell,
  input  wire logic                             cfg_write,
  input  wire logic [gs1d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gs1d_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gs1d_pkg::cfg_t    cfg;
  gs1d_pkg::cmd_t    cmd;
  gs1d_pkg::status_t status;

  gs1d_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gs1d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .last       (last),
    .status     (status),
    .cmd        (cmd)
  );

  gs1d_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .initial_value (initial_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cell_value    (cell_value),
    .cell_index    (cell_index),
    .sweeps_done   (sweeps_done),
    .not_converged (not_converged),
    .final_cell    (final_cell)
  );

endmodule

`default_nettype wire

### rtl/core/gs1d_checker.sv
// Port-level checks for the 1D Gauss-Seidel Laplace solver, bound to its top level.
// Depends on gs1d_pkg for the cell count and the configuration port widths.
`default_nettype none

module gs1d_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             item_valid,
  input wire logic                             item_stall,
  input wire logic signed [31:0]               initial_value,
  input wire logic                             last,
  input wire logic                             result_valid,
  input wire logic                             result_stall,
  input wire logic signed [31:0]               cell_value,
  input wire logic [5:0]                       cell_index,
  input wire logic [15:0]                      sweeps_done,
  input wire logic                             not_converged,
  input wire logic                             final_cell,
  input wire logic                             cfg_write,
  input wire logic [gs1d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [gs1d_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cell_value)
      && $stable(cell_index) && $stable(final_cell))
    else $error("stalled result changed");

  // The closing result of a run belongs to the last cell.
  a_final_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && final_cell |-> cell_index == 6'(gs1d_pkg::CELLS - 1))
    else $error("final_cell on a cell other than the last");

  // While a run is still emitting, no new load is taken.
  a_no_load_midrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && !final_cell |-> item_stall)
    else $error("input open while results of a run are pending");

  // Every solve runs at least one sweep.
  a_sweeps_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sweeps_done != 16'd0)
    else $error("result reports zero sweeps");

endmodule

bind gauss_seidel_1d_laplace_solver gs1d_checker u_gs1d_checker (.*);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the 1D Gauss-Seidel Laplace solver top level.
// Depends on gs1d_pkg and gauss_seidel_1d_laplace_solver; holds its own model
// of the relaxation and compares every result cell against it.
module testbench;

  localparam int CELLS      = gs1d_pkg::CELLS;
  localparam int CFG_IDX_W  = gs1d_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gs1d_pkg::CFG_DATA_W;

  localparam int ITEMS_TOTAL   = 430;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  logic signed [31:0]    initial_value;
  logic                  last;
  logic                  result_valid;
  logic                  result_stall;
  logic signed [31:0]    cell_value;
  logic [5:0]            cell_index;
  logic [15:0]           sweeps_done;
  logic                  not_converged;
  logic                  final_cell;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gauss_seidel_1d_laplace_solver dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .initial_value(initial_value), .last(last),
    .result_valid(result_valid), .result_stall(result_stall),
    .cell_value(cell_value), .cell_index(cell_index), .sweeps_done(sweeps_done),
    .not_converged(not_converged), .final_cell(final_cell),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         index;
    logic [15:0]        sweeps;
    logic               stuck;
    logic               closing;
  } cell_result_t;

  // Model copy of the registers, starting from their reset values.
  logic signed [31:0] wall_temp_m = 32'sd6553600;
  logic signed [31:0] wall_flux_m = 32'sd6553600;
  logic [30:0]        width_m     = 31'd6554;
  logic [30:0]        tol_m       = 31'd0;
  logic [15:0]        limit_m     = 16'hFFFF;

  logic signed [31:0] field_m [CELLS];
  int                 loaded_m = 0;
  cell_result_t       expected_cells[$];

  int sent_items  = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  bit gaps_on     = 1'b0;
  bit stalls_on   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Runs sweeps over the loaded field until it settles or the limit is hit,
  // then queues one expected result per cell.
  function automatic void solve_field();
    longint       flux_term, left_ghost, right_ghost, lhs, rhs, half, delta, worst;
    int unsigned  cap, count;
    logic         stuck;
    cell_result_t r;
    for (int i = loaded_m; i < CELLS; i++) field_m[i] = '0;
    loaded_m = 0;
    cap = (limit_m == 16'd0) ? 1 : limit_m;
    count = 0;
    stuck = 1'b0;
    flux_term = clamp32((longint'(wall_flux_m) * longint'(width_m) + 64'sd32768) >>> 16);
    forever begin
      count++;
      left_ghost  = clamp32(2 * longint'(wall_temp_m) - longint'(field_m[0]));
      right_ghost = clamp32(flux_term + longint'(field_m[CELLS-1]));
      worst = 0;
      for (int i = 0; i < CELLS; i++) begin
        lhs   = (i == 0) ? left_ghost : longint'(field_m[i-1]);
        rhs   = (i == CELLS - 1) ? right_ghost : longint'(field_m[i+1]);
        // The halved sum of two 32-bit values always fits 32 bits.
        half  = (lhs + rhs) >>> 1;
        delta = half - longint'(field_m[i]);
        if (delta < 0) delta = -delta;
        if (delta > worst) worst = delta;
        field_m[i] = half[31:0];
      end
      if (worst <= longint'(tol_m)) break;
      if (count >= cap) begin
        stuck = 1'b1;
        break;
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      r.value   = field_m[i];
      r.index   = 6'(i);
      r.sweeps  = 16'(count);
      r.stuck   = stuck;
      r.closing = (i == CELLS - 1);
      expected_cells.push_back(r);
    end
  endfunction

  function automatic void load_cell(input logic signed [31:0] v, input logic l);
    if (loaded_m < CELLS) begin
      field_m[loaded_m] = v;
      loaded_m++;
    end
    if (l || loaded_m >= CELLS) solve_field();
  endfunction

  function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
    case (idx)
      gs1d_pkg::REG_WALL_TEMPERATURE: wall_temp_m = d;
      gs1d_pkg::REG_WALL_FLUX:        wall_flux_m = d;
      gs1d_pkg::REG_CELL_WIDTH:       width_m = d[30:0];
      gs1d_pkg::REG_TOLERANCE:        tol_m = d[30:0];
      gs1d_pkg::REG_SWEEP_LIMIT:      limit_m = d[15:0];
      default: ;
    endcase
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] corner_value(input int k);
    logic signed [31:0] v;
    case (k % 6)
      0: v = 32'sh7FFFFFFF;
      1: v = 32'sh80000000;
      2: v = 32'sh55555555;
      3: v = 32'shAAAAAAAA;
      4: v = 32'sh00000000;
      default: v = -32'sd1;
    endcase
    return v;
  endfunction

  // Moderate values keep every change of a sweep well inside 31 bits.
  function automatic logic signed [31:0] pick_value(input bit moderate);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (moderate) return $signed($urandom_range(0, 2**24)) - 2**23;
    if (r < 40) return $urandom;
    if (r < 80) return $signed($urandom_range(0, 131071)) - 65536;
    return corner_value($urandom_range(0, 5));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    model_write(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] temp, input logic [31:0] flux,
                            input logic [31:0] width, input logic [31:0] tol,
                            input logic [31:0] lim);
    write_reg(gs1d_pkg::REG_WALL_TEMPERATURE, temp);
    write_reg(gs1d_pkg::REG_WALL_FLUX, flux);
    write_reg(gs1d_pkg::REG_CELL_WIDTH, width);
    write_reg(gs1d_pkg::REG_TOLERANCE, tol);
    write_reg(gs1d_pkg::REG_SWEEP_LIMIT, lim);
  endtask

  task automatic send_cell(input logic signed [31:0] v, input logic l);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid    = 1'b0;
      initial_value = $urandom;
      last          = $urandom_range(0, 1);
      repeat (gap) @(negedge clk);
    end
    item_valid    = 1'b1;
    initial_value = v;
    last          = l;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    load_cell(v, l);
    sent_items++;
  endtask

  // A run without last on its final cell is only sent full length.
  task automatic send_run(input int len, input bit close_with_last, input bit moderate);
    for (int k = 0; k < len; k++) begin
      send_cell(pick_value(moderate), close_with_last && (k == len - 1));
    end
  endtask

  task automatic send_random_run(input bit moderate);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_run(CELLS, 1'b0, moderate);
    end else if (r < 25) begin
      send_run(CELLS, 1'b1, moderate);
    end else begin
      send_run($urandom_range(1, CELLS - 1), 1'b1, moderate);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // Only the sweep limit is lowered; the other registers keep reset values.
    write_reg(gs1d_pkg::REG_SWEEP_LIMIT, 32'd5);
    send_cell(32'sh00010000, 1'b0);
    send_cell(-32'sh00030000, 1'b0);
    send_cell(32'sh7FFF0000, 1'b1);
    drain();
  endtask

  task automatic test_directed_cases();
    // An all-zero field with zero boundaries settles on the only allowed sweep.
    set_config(32'd0, 32'd0, 32'd6554, 32'd0, 32'd1);
    send_cell(32'sd0, 1'b1);
    drain();
    // A sweep limit of zero still runs one sweep.
    write_reg(gs1d_pkg::REG_SWEEP_LIMIT, 32'hABCD0000);
    send_cell(32'sh7FFFFFFF, 1'b1);
    drain();
    // Filling every cell starts the solve without last; boundaries saturate.
    set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd0, 32'd2);
    for (int k = 0; k < CELLS; k++) send_cell(corner_value(k), 1'b0);
    drain();
    send_cell(32'sh80000000, 1'b0);
    send_cell(32'sh55555555, 1'b1);
    drain();
  endtask

  task automatic test_unknown_index();
    set_config(32'd655360, 32'd65536, 32'd6554, 32'd16, 32'd8);
    for (int i = gs1d_pkg::REG_SWEEP_LIMIT + 1; i < 2**CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    send_run(5, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_config_extremes();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: set_config(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd3);
        1: set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd2);
        default: set_config(32'd0, 32'h7FFFFFFF, 32'd0, 32'd1, 32'h55550004);
      endcase
      send_random_run(1'b0);
      send_random_run(1'b0);
      drain();
    end
  endtask

  task automatic test_convergence();
    // A loose tolerance settles in one sweep, so the largest limit is safe here.
    set_config($urandom_range(0, 2**22), $urandom_range(0, 2**20), 32'd6554,
               32'h7FFFFFFF, {16'($urandom), 16'hFFFF});
    repeat (3) send_random_run(1'b1);
    drain();
    for (int s = 0; s < 3; s++) begin
      set_config($urandom_range(0, 2**22), $urandom_range(0, 2**20), 32'd6554,
                 32'd1 << (12 + 4 * s), $urandom_range(16, 48));
      repeat (2) send_random_run(1'b1);
      drain();
    end
  endtask

  task automatic test_random_runs();
    logic [31:0] tol;
    int unsigned r;
    while (sent_items < ITEMS_TOTAL) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 3);
      tol = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(0, 2**20);
      set_config(pick_value(1'b0), pick_value(1'b0), $urandom, tol,
                 {16'($urandom), 16'($urandom_range(0, 40))});
      repeat ($urandom_range(3, 7)) send_random_run($urandom_range(0, 1));
      drain();
    end
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 99) < 35) begin
        result_stall = 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_cells
    cell_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_cells.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("unexpected result: cell %0d value %h", cell_index, cell_value);
        end
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (cell_value !== want.value || cell_index !== want.index ||
            sweeps_done !== want.sweeps || not_converged !== want.stuck ||
            final_cell !== want.closing) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: expected cell %0d value %h sweeps %0d nc %b final %b",
                     want.index, want.value, want.sweeps, want.stuck, want.closing);
            $display("          got      cell %0d value %h sweeps %0d nc %b final %b",
                     cell_index, cell_value, sweeps_done, not_converged, final_cell);
          end
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    initial_value = '0;
    last          = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    for (int i = 0; i < CELLS; i++) field_m[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_unknown_index();
    test_config_extremes();
    test_convergence();
    test_random_runs();

    if (expected_cells.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
